[sv/alm_pkg.sv]
package alm_pkg;

    // block length limit and derived counter width
    localparam int MAX_BLOCK = 4096;
    localparam int CNT_W     = $clog2(MAX_BLOCK + 1);

    // sum of squares, Q.30 units, saturating
    localparam int SUM_W = 42;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // amplitude to level constants
    localparam logic [16:0] SILENCE_AMP  = 17'd32;
    localparam logic [20:0] FULL_LOG2    = 21'(15 * 65536);
    localparam logic [16:0] DB_SLOPE_Q20 = 17'd105218;
    localparam logic [15:0] FLOOR_VALUE  = 16'd656;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_PEAK_HOLD   = 3'd0,
        CFG_DECAY_IDLE  = 3'd1,
        CFG_CLEAR_IDLE  = 3'd2,
        CFG_LEVEL_DECAY = 3'd3,
        CFG_PEAK_DECAY  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] peak_hold_ms;
        logic [15:0] decay_idle_ms;
        logic [15:0] clear_idle_ms;
        logic [15:0] level_decay_factor;
        logic [15:0] peak_decay_factor;
    } t_cfg;

    // one job handed from the front to the back
    typedef struct packed {
        logic             is_tick;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
        logic [16:0]      peak;
        logic [31:0]      now_ms;
    } t_job;

    // log2(1 + i/16) in Q1.16
    function automatic logic [16:0] log2_tab(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd5732;
            5'd2:    v = 17'd11136;
            5'd3:    v = 17'd16248;
            5'd4:    v = 17'd21098;
            5'd5:    v = 17'd25711;
            5'd6:    v = 17'd30109;
            5'd7:    v = 17'd34312;
            5'd8:    v = 17'd38336;
            5'd9:    v = 17'd42196;
            5'd10:   v = 17'd45904;
            5'd11:   v = 17'd49472;
            5'd12:   v = 17'd52911;
            5'd13:   v = 17'd56229;
            5'd14:   v = 17'd59434;
            5'd15:   v = 17'd62534;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    // "now is after t" in wrapping ms time
    function automatic logic is_after(input logic [31:0] now, input logic [31:0] t);
        logic [31:0] diff;
        diff = now - t;
        return (diff != 32'd0) && !diff[31];
    endfunction

    function automatic logic [15:0] floored(input logic [15:0] v);
        return (v < FLOOR_VALUE) ? 16'd0 : v;
    endfunction

endpackage

[sv/audio_level_meter_peak_hold_top.sv]
// Audio level meter with peak hold.
// Input channel (i_in_valid / o_in_stall) carries one beat per audio sample
// (i_cmd = 0) or decay timer tick (i_cmd = 1) with its ms timestamp.
// Samples are summed and peak-tracked in the front at one beat per cycle
// unless the queue is full; i_last, or a block reaching MAX_BLOCK samples,
// hands the block to the back through a two-entry job queue, as does every
// tick. The back produces at most one result beat per job on o_out_valid /
// i_out_stall. A block job passes through the back in order: the pop in the
// idle state, 42 divider steps for the mean square, 21 square root steps,
// the log, drop and level states for RMS and then for peak, the update
// state and the output state. A tick with no result ends in the tick state;
// one that clears the meter goes on to the output state, one that decays it
// through the peak decay and output states. The input stalls only while the
// job queue holds two jobs, so sample beats stream at one per cycle as long
// as blocks end no faster than the back drains them.
// A stalled result stays in the output register; the back then waits with
// the next result, and the queue fills behind it.
// Configuration: i_cfg_valid / o_cfg_ready (always ready), write only while
// the block is idle. Reset (synchronous, active low) restores default
// register values and clears accumulators, meter and queue.
module audio_level_meter_peak_hold_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_cmd,
    input  logic signed [15:0] i_sample,
    input  logic               i_last,
    input  logic [31:0]        i_now_ms,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_level_out,
    output logic [15:0]        o_peak_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    alm_pkg::t_cfg r_cfg, n_cfg;
    alm_pkg::t_job push_job, pop_job;
    logic          push, pop, q_full, q_empty;

    assign o_cfg_ready = 1'b1;

    // configuration register writes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (alm_pkg::t_cfg_idx'(i_cfg_index))
                alm_pkg::CFG_PEAK_HOLD:   n_cfg.peak_hold_ms       = i_cfg_data;
                alm_pkg::CFG_DECAY_IDLE:  n_cfg.decay_idle_ms      = i_cfg_data;
                alm_pkg::CFG_CLEAR_IDLE:  n_cfg.clear_idle_ms      = i_cfg_data;
                alm_pkg::CFG_LEVEL_DECAY: n_cfg.level_decay_factor = i_cfg_data;
                alm_pkg::CFG_PEAK_DECAY:  n_cfg.peak_decay_factor  = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.peak_hold_ms       <= 16'd320;
            r_cfg.decay_idle_ms      <= 16'd120;
            r_cfg.clear_idle_ms      <= 16'd450;
            r_cfg.level_decay_factor <= 16'd51118;
            r_cfg.peak_decay_factor  <= 16'd58982;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    alm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_cmd    (i_cmd),
        .i_sample (i_sample),
        .i_last   (i_last),
        .i_now_ms (i_now_ms),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    alm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (q_empty)
    );

    alm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (q_empty),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_level_out (o_level_out),
        .o_peak_out  (o_peak_out)
    );

endmodule

[sv/alm_front.sv]
module alm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_cmd,
    input  logic signed [15:0] i_sample,
    input  logic               i_last,
    input  logic [31:0]        i_now_ms,
    input  logic               i_q_full,
    output logic               o_push,
    output alm_pkg::t_job      o_job
);

    logic [alm_pkg::SUM_W-1:0] r_sum, n_sum;
    logic [16:0]               r_peak, n_peak;
    logic [alm_pkg::CNT_W-1:0] r_cnt, n_cnt;

    logic                      accept;
    logic [16:0]               mag;
    logic [33:0]               sq_full;
    logic [alm_pkg::SUM_W:0]   sum_add;
    logic [alm_pkg::SUM_W-1:0] sum_new;
    logic [16:0]               peak_new;
    logic [alm_pkg::CNT_W-1:0] cnt_new;
    logic                      blk_end;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;

    // per-sample accumulation
    always_comb begin
        mag      = i_sample[15] ? (17'h10000 - {1'b0, $unsigned(i_sample)})
                                : {1'b0, $unsigned(i_sample)};
        sq_full  = mag * mag;
        sum_add  = {1'b0, r_sum} + (alm_pkg::SUM_W+1)'(sq_full);
        sum_new  = sum_add[alm_pkg::SUM_W] ? alm_pkg::SUM_MAX : sum_add[alm_pkg::SUM_W-1:0];
        peak_new = (mag > r_peak) ? mag : r_peak;
        cnt_new  = r_cnt + 1'b1;
        blk_end  = i_last || (cnt_new == alm_pkg::CNT_W'(alm_pkg::MAX_BLOCK));
    end

    // job to the queue: every tick, every block end
    always_comb begin
        o_push         = accept && (i_cmd || blk_end);
        o_job.is_tick  = i_cmd;
        o_job.sum      = sum_new;
        o_job.cnt      = cnt_new;
        o_job.peak     = peak_new;
        o_job.now_ms   = i_now_ms;
    end

    always_comb begin
        n_sum  = r_sum;
        n_peak = r_peak;
        n_cnt  = r_cnt;
        if (accept && !i_cmd) begin
            if (blk_end) begin
                n_sum  = '0;
                n_peak = '0;
                n_cnt  = '0;
            end else begin
                n_sum  = sum_new;
                n_peak = peak_new;
                n_cnt  = cnt_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_peak <= '0;
            r_cnt  <= '0;
        end else begin
            r_sum  <= n_sum;
            r_peak <= n_peak;
            r_cnt  <= n_cnt;
        end
    end

endmodule

[sv/alm_queue.sv]
module alm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  alm_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output alm_pkg::t_job o_job,
    output logic          o_empty
);

    // two-entry job queue
    alm_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

[sv/alm_back.sv]
module alm_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  alm_pkg::t_cfg i_cfg,
    input  logic          i_q_empty,
    input  alm_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [15:0]   o_level_out,
    output logic [15:0]   o_peak_out
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_DIV  = 10'b0000000010,
        S_SQRT = 10'b0000000100,
        S_LOGD = 10'b0000001000,
        S_DROP = 10'b0000010000,
        S_LVL  = 10'b0000100000,
        S_BUPD = 10'b0001000000,
        S_TICK = 10'b0010000000,
        S_PKD  = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    localparam int SW = alm_pkg::SUM_W;
    localparam int CW = alm_pkg::CNT_W;

    t_state          r_state, n_state;
    alm_pkg::t_job   r_job, n_job;
    logic [5:0]      r_iter, n_iter;
    logic [CW-1:0]   r_rem, n_rem;
    logic [SW-1:0]   r_quo, n_quo;
    logic [SW-1:0]   r_sv, n_sv;
    logic [SW:0]     r_res, n_res;
    logic [SW-1:0]   r_bit, n_bit;
    logic            r_sel, n_sel;
    logic            r_zero, n_zero;
    logic [19:0]     r_d, n_d;
    logic [17:0]     r_drop, n_drop;
    logic [15:0]     r_lvl_rms, n_lvl_rms;
    logic [15:0]     r_lvl_pk, n_lvl_pk;
    logic [15:0]     r_mlevel, n_mlevel;
    logic [15:0]     r_mpeak, n_mpeak;
    logic [31:0]     r_utime, n_utime;
    logic            r_uvalid, n_uvalid;
    logic [31:0]     r_hold, n_hold;
    logic            r_ovalid, n_ovalid;
    logic [15:0]     r_olevel, n_olevel;
    logic [15:0]     r_opeak, n_opeak;

    // divider step
    logic [CW:0]     div_t;
    logic [CW:0]     div_sub;
    // square root step
    logic [SW:0]     sq_rb;
    // log2 stage
    logic [16:0]     amp;
    logic [3:0]      lg_e;
    logic [15:0]     lg_sh;
    logic [14:0]     lg_m;
    logic [16:0]     t_lo, t_hi;
    logic [23:0]     lg_prod;
    logic [16:0]     lg_lf;
    logic [20:0]     lg_l;
    logic [37:0]     drop_prod;
    logic [15:0]     lvl_val;
    // meter math
    logic [31:0]     pk_scaled;
    logic [31:0]     lv_scaled;
    logic [31:0]     elapsed;
    logic            out_free;

    assign o_valid     = r_ovalid;
    assign o_level_out = r_olevel;
    assign o_peak_out  = r_opeak;
    assign out_free    = !r_ovalid || !i_stall;

    always_comb begin
        // restoring division, one quotient bit per cycle
        div_t   = {r_rem, r_quo[SW-1]};
        div_sub = div_t - {1'b0, r_job.cnt};
        // square root, one result bit per cycle
        sq_rb   = r_res + {1'b0, r_bit};
        // operand of the level unit, amplitudes clamp at full scale
        if (!r_sel) begin
            amp = (r_res > (SW+1)'(32768)) ? 17'd32768 : r_res[16:0];
        end else begin
            amp = r_job.peak;
        end
        lg_e = 4'd0;
        for (int k = 0; k < 16; k++) begin
            if (amp[k]) lg_e = 4'(k);
        end
        lg_sh   = amp[15:0] << (4'd15 - lg_e);
        lg_m    = lg_sh[14:0];
        t_lo    = alm_pkg::log2_tab({1'b0, lg_m[14:11]});
        t_hi    = alm_pkg::log2_tab({1'b0, lg_m[14:11]} + 5'd1);
        lg_prod = 24'(t_hi - t_lo) * {13'd0, lg_m[10:0]};
        lg_lf   = t_lo + {4'd0, lg_prod[23:11]};
        lg_l    = {1'b0, lg_e, 16'd0} + {4'd0, lg_lf};
        drop_prod = {18'd0, r_d} * {21'd0, alm_pkg::DB_SLOPE_Q20} + 38'(1 << 19);
        if (r_zero || r_drop[17:16] != 2'd0) begin
            lvl_val = 16'd0;
        end else if (r_drop[15:0] == 16'd0) begin
            lvl_val = 16'hFFFF;
        end else begin
            lvl_val = 16'(17'h10000 - {1'b0, r_drop[15:0]});
        end
        pk_scaled = r_mpeak * i_cfg.peak_decay_factor;
        lv_scaled = r_mlevel * i_cfg.level_decay_factor;
        elapsed   = r_job.now_ms - r_utime;
    end

    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        n_iter    = r_iter;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_sv      = r_sv;
        n_res     = r_res;
        n_bit     = r_bit;
        n_sel     = r_sel;
        n_zero    = r_zero;
        n_d       = r_d;
        n_drop    = r_drop;
        n_lvl_rms = r_lvl_rms;
        n_lvl_pk  = r_lvl_pk;
        n_mlevel  = r_mlevel;
        n_mpeak   = r_mpeak;
        n_utime   = r_utime;
        n_uvalid  = r_uvalid;
        n_hold    = r_hold;
        n_ovalid  = r_ovalid && i_stall;
        n_olevel  = r_olevel;
        n_opeak   = r_opeak;
        o_pop     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop  = 1'b1;
                    n_job  = i_job;
                    n_rem  = '0;
                    n_quo  = i_job.sum;
                    n_iter = '0;
                    n_state = i_job.is_tick ? S_TICK : S_DIV;
                end
            end
            S_DIV: begin
                if (!div_sub[CW]) begin
                    n_rem = div_sub[CW-1:0];
                    n_quo = {r_quo[SW-2:0], 1'b1};
                end else begin
                    n_rem = div_t[CW-1:0];
                    n_quo = {r_quo[SW-2:0], 1'b0};
                end
                n_iter = r_iter + 6'd1;
                if (r_iter == 6'(SW - 1)) begin
                    n_iter  = '0;
                    n_sv    = n_quo;
                    n_res   = '0;
                    n_bit   = SW'(1) << (SW - 2);
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if ({1'b0, r_sv} >= sq_rb) begin
                    n_sv  = SW'({1'b0, r_sv} - sq_rb);
                    n_res = (r_res >> 1) + {1'b0, r_bit};
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit  = r_bit >> 2;
                n_iter = r_iter + 6'd1;
                if (r_iter == 6'(SW / 2 - 1)) begin
                    n_sel   = 1'b0;
                    n_state = S_LOGD;
                end
            end
            S_LOGD: begin
                n_zero = (amp <= alm_pkg::SILENCE_AMP);
                n_d    = (lg_l >= alm_pkg::FULL_LOG2) ? 20'd0
                                                      : 20'(alm_pkg::FULL_LOG2 - lg_l);
                n_state = S_DROP;
            end
            S_DROP: begin
                n_drop  = drop_prod[37:20];
                n_state = S_LVL;
            end
            S_LVL: begin
                if (!r_sel) begin
                    n_lvl_rms = lvl_val;
                    n_sel     = 1'b1;
                    n_state   = S_LOGD;
                end else begin
                    n_lvl_pk  = lvl_val;
                    n_state   = S_BUPD;
                end
            end
            S_BUPD: begin
                n_mlevel = r_lvl_rms;
                n_utime  = r_job.now_ms;
                n_uvalid = 1'b1;
                if (r_lvl_pk >= r_mpeak) begin
                    n_mpeak = r_lvl_pk;
                    n_hold  = r_job.now_ms + {16'd0, i_cfg.peak_hold_ms};
                end else if (alm_pkg::is_after(r_job.now_ms, r_hold)) begin
                    n_mpeak = alm_pkg::floored((r_lvl_pk > pk_scaled[31:16]) ? r_lvl_pk
                                                                            : pk_scaled[31:16]);
                end
                n_state = S_OUT;
            end
            S_TICK: begin
                if (r_mlevel == 16'd0 && r_mpeak == 16'd0) begin
                    n_state = S_IDLE;
                end else if (r_uvalid && elapsed < {16'd0, i_cfg.decay_idle_ms}) begin
                    n_state = S_IDLE;
                end else if (r_uvalid && elapsed >= {16'd0, i_cfg.clear_idle_ms}) begin
                    n_mlevel = '0;
                    n_mpeak  = '0;
                    n_utime  = '0;
                    n_uvalid = 1'b0;
                    n_hold   = '0;
                    n_state  = S_OUT;
                end else begin
                    n_mlevel = alm_pkg::floored(lv_scaled[31:16]);
                    n_state  = S_PKD;
                end
            end
            S_PKD: begin
                if (alm_pkg::is_after(r_job.now_ms, r_hold)) begin
                    n_mpeak = alm_pkg::floored(pk_scaled[31:16]);
                end else begin
                    n_mpeak = alm_pkg::floored(r_mpeak);
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_olevel = r_mlevel;
                    n_opeak  = r_mpeak;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control and meter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mlevel <= '0;
            r_mpeak  <= '0;
            r_utime  <= '0;
            r_uvalid <= 1'b0;
            r_hold   <= '0;
            r_ovalid <= 1'b0;
            r_iter   <= '0;
            r_sel    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mlevel <= n_mlevel;
            r_mpeak  <= n_mpeak;
            r_utime  <= n_utime;
            r_uvalid <= n_uvalid;
            r_hold   <= n_hold;
            r_ovalid <= n_ovalid;
            r_iter   <= n_iter;
            r_sel    <= n_sel;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_sv      <= n_sv;
        r_res     <= n_res;
        r_bit     <= n_bit;
        r_zero    <= n_zero;
        r_d       <= n_d;
        r_drop    <= n_drop;
        r_lvl_rms <= n_lvl_rms;
        r_lvl_pk  <= n_lvl_pk;
        r_olevel  <= n_olevel;
        r_opeak   <= n_opeak;
    end

endmodule
